### hw/rtl/distance_vector_table_update_defines.svh
// Assertion macros for the distance vector table update block
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DVTU_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dvtu assertion failed");

// next-cycle implication, checked outside reset
`define DVTU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dvtu assertion failed");

`endif

### hw/rtl/dvtu_pkg.sv
// Shared types and constants of the distance vector table update block
package dvtu_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] NEIGHBOR_RESET = 8'd67;
    localparam logic [7:0] DIST_MAX       = 8'd255;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ADVERT = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_ENTRY    = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] name;
        logic [7:0]  cost;
        logic [7:0]  hop;
    } cmd_t;

    typedef struct packed {
        logic [15:0] name;
        logic [7:0]  cost;
        logic [7:0]  hop;
    } entry_t;

endpackage

### hw/rtl/dvtu_front.sv
// Input side: accept items, drop meaningless modes, precompute learned distance
module dvtu_front
    import dvtu_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] dest_name,
    input  logic [7:0]  distance,
    input  logic [7:0]  next_hop,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_wdata
);

    mode_t      mode_in;
    logic [7:0] adv_dist;

    assign mode_in  = mode_t'(mode);
    assign adv_dist = (distance == DIST_MAX) ? DIST_MAX : distance + 8'd1;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && (mode_in != MODE_NONE);

    always_comb
    begin
        q_wdata.mode = mode_in;
        q_wdata.name = dest_name;
        q_wdata.cost = (mode_in == MODE_ADVERT) ? adv_dist : distance;
        q_wdata.hop  = next_hop;
    end

endmodule

### hw/rtl/dvtu_queue.sv
// Short command queue between the front and back parts
module dvtu_queue
    import dvtu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t wdata,
    output cmd_t rdata,
    input  logic push,
    output logic full,
    input  logic pop,
    output logic avail
);

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### hw/rtl/dvtu_back.sv
// Table engine: table memory, search, shift insert, dump and result register
module dvtu_back
    import dvtu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       neighbor_id,
    input  logic             q_avail,
    input  cmd_t             q_rdata,
    output logic             q_pop,
    output logic [CNT_W-1:0] entry_count,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [15:0]      entry_name,
    output logic [7:0]       entry_distance,
    output logic [7:0]       entry_next_hop,
    output logic             last
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_DUMP   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    entry_t             mem [TABLE_DEPTH];
    entry_t             rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   ins_pos_reg, ins_pos_next;
    logic               larger_reg, larger_next;
    status_t            res_reg, res_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    entry_t             out_entry_reg, out_entry_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic [CNT_W-1:0]   count_last;
    logic               at_last;
    logic               larger_now;
    logic               table_full;
    entry_t             new_entry;

    assign out_free   = !out_valid_reg || out_ready;
    assign count_last = count_reg - 1'b1;
    assign at_last    = (CNT_W'(k_reg) == count_last);
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign larger_now = !larger_reg && (cmd_reg.name < rd_data_reg.name);
    assign new_entry  = '{name: cmd_reg.name, cost: cmd_reg.cost, hop: neighbor_id};

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        ins_pos_next    = ins_pos_reg;
        larger_next     = larger_reg;
        res_next        = res_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = k_reg;
        wr_data         = rd_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_rdata;
                    case (q_rdata.mode)
                        MODE_LOAD:
                        begin
                            if (table_full)
                                res_next = ST_DROPPED;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = '{name: q_rdata.name, cost: q_rdata.cost,
                                               hop: q_rdata.hop};
                                count_next = count_reg + 1'b1;
                                res_next   = ST_ACCEPTED;
                            end
                            state_next = S_RESULT;
                        end
                        MODE_ADVERT:
                        begin
                            k_next      = '0;
                            ins_pos_next = '0;
                            larger_next = 1'b0;
                            if (count_reg == '0)
                                state_next = S_SHIFT;
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_SEARCH;
                            end
                        end
                        MODE_DUMP:
                        begin
                            k_next = '0;
                            if (count_reg == '0)
                            begin
                                res_next   = ST_EMPTY;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (rd_data_reg.name == cmd_reg.name)
                begin
                    if (rd_data_reg.hop == neighbor_id || cmd_reg.cost < rd_data_reg.cost)
                    begin
                        wr_en   = 1'b1;
                        wr_data = new_entry;
                    end
                    res_next   = ST_ACCEPTED;
                    state_next = S_RESULT;
                end
                else
                begin
                    if (larger_now)
                    begin
                        larger_next  = 1'b1;
                        ins_pos_next = k_reg;
                    end
                    if (at_last)
                    begin
                        if (table_full)
                        begin
                            res_next   = ST_DROPPED;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            if (!larger_reg && !larger_now)
                                ins_pos_next = count_reg[IDX_W-1:0];
                            k_next     = count_reg[IDX_W-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = count_last[IDX_W-1:0];
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = k_reg + 1'b1;
                        k_next  = k_reg + 1'b1;
                    end
                end
            end

            S_SHIFT:
            begin
                wr_en = 1'b1;
                if (k_reg == ins_pos_reg)
                begin
                    wr_data    = new_entry;
                    count_next = count_reg + 1'b1;
                    res_next   = ST_ACCEPTED;
                    state_next = S_RESULT;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                    if (k_reg - 1'b1 != ins_pos_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = k_reg - IDX_W'(2);
                    end
                end
            end

            S_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_ENTRY;
                    out_entry_next  = rd_data_reg;
                    out_last_next   = at_last;
                    if (at_last)
                        state_next = S_IDLE;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = k_reg + 1'b1;
                        k_next  = k_reg + 1'b1;
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_entry_next  = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        k_reg          <= k_next;
        ins_pos_reg    <= ins_pos_next;
        larger_reg     <= larger_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign entry_count    = count_reg;
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign entry_name     = out_entry_reg.name;
    assign entry_distance = out_entry_reg.cost;
    assign entry_next_hop = out_entry_reg.hop;
    assign last           = out_last_reg;

endmodule

### hw/rtl/distance_vector_table_update.sv
// Top level of the distance vector routing table update block
//
// Input channel (in_valid/in_ready) carries one item per handshake: a mode,
// a destination name, a distance and a next hop. Load items append an entry,
// advertisements update or insert a route via the neighbor in cfg_wdata,
// dump items read the table out, and mode three items are dropped.
// Output channel (out_valid/out_ready) returns results; last marks the
// final result of an item. Load and advertisement give one result each.
// Items pass a four-deep command queue, so the input keeps taking items
// while the table engine or the output register is busy.
// Advertisement time is bound by the single-port scan and the
// one-entry-per-cycle shift through the table memory; a dump returns the
// n entries of the table one result per cycle while out_ready stays high.
// Reset empties the table (entry count zero) and sets the neighbor to 67.
// When the receiver stalls, the result register holds, the engine waits,
// and the queue fills until in_ready drops.
module distance_vector_table_update
    import dvtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] dest_name,
    input  logic [7:0]  distance,
    input  logic [7:0]  next_hop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] entry_name,
    output logic [7:0]  entry_distance,
    output logic [7:0]  entry_next_hop,
    output logic        last
);

`include "distance_vector_table_update_defines.svh"

    logic [7:0]       neighbor_id_reg;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_avail;
    cmd_t             q_wdata;
    cmd_t             q_rdata;
    logic [CNT_W-1:0] entry_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            neighbor_id_reg <= NEIGHBOR_RESET;
        else if (cfg_we)
            neighbor_id_reg <= cfg_wdata;
    end

    dvtu_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .dest_name (dest_name),
        .distance  (distance),
        .next_hop  (next_hop),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    dvtu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wdata (q_wdata),
        .rdata (q_rdata),
        .push  (q_push),
        .full  (q_full),
        .pop   (q_pop),
        .avail (q_avail)
    );

    dvtu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .neighbor_id    (neighbor_id_reg),
        .q_avail        (q_avail),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .entry_count    (entry_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .entry_name     (entry_name),
        .entry_distance (entry_distance),
        .entry_next_hop (entry_next_hop),
        .last           (last)
    );

    `DVTU_ASSERT_IMPL(a_count_bound, 1'b1, entry_count <= CNT_W'(TABLE_DEPTH))
    `DVTU_ASSERT_NEXT(a_count_step, 1'b1,
        entry_count == $past(entry_count) || entry_count == $past(entry_count) + 1'b1)
    `DVTU_ASSERT_IMPL(a_single_result,
        out_valid && (status == ST_ACCEPTED || status == ST_DROPPED || status == ST_EMPTY),
        last && entry_name == '0 && entry_distance == '0 && entry_next_hop == '0)
    `DVTU_ASSERT_IMPL(a_none_dropped,
        in_valid && in_ready && mode_t'(mode) == MODE_NONE, !q_push)

endmodule
